/* rtl/ymd_pkg.sv */
// shared types, constants and crc function for the ymodem packet deframer
package ymd_pkg;

  localparam logic [7:0] MK_SOH = 8'h01;
  localparam logic [7:0] MK_STX = 8'h02;
  localparam logic [7:0] MK_EOT = 8'h04;
  localparam logic [7:0] MK_CAN = 8'h18;

  localparam logic [15:0] CRC_POLY = 16'h1021;
  localparam logic [7:0]  SEQ_SUM  = 8'hff;

  localparam logic [10:0] SHORT_LEN = 11'd128;
  localparam logic [10:0] LONG_LEN  = 11'd1024;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_EOT        = 3'd1;
  localparam logic [2:0] ST_CAN        = 3'd2;
  localparam logic [2:0] ST_BAD_MARKER = 3'd3;
  localparam logic [2:0] ST_BAD_HEADER = 3'd4;
  localparam logic [2:0] ST_BAD_CRC    = 3'd5;
  localparam logic [2:0] ST_TIMEOUT    = 3'd6;

  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic [9:0]  byte_index;
    logic [2:0]  status;
    logic [7:0]  block_number;
    logic [10:0] packet_length;
  } res_t;

  // crc-16/xmodem, one byte, msb first
  function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int k = 0; k < 8; k++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* rtl/ymd_in_if.sv */
// input channel: received byte or timeout event
interface ymd_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] rx_byte;

  modport source (output valid, output action, output rx_byte, input ready);
  modport sink (input valid, input action, input rx_byte, output ready);
endinterface

/* rtl/ymd_out_if.sv */
// output channel: payload byte or packet status
interface ymd_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  data_byte;
  logic [9:0]  byte_index;
  logic [2:0]  status;
  logic [7:0]  block_number;
  logic [10:0] packet_length;

  modport source (output valid, output kind, output data_byte, output byte_index,
                  output status, output block_number, output packet_length,
                  input ready);
  modport sink (input valid, input kind, input data_byte, input byte_index,
                input status, input block_number, input packet_length,
                output ready);
endinterface

/* rtl/ymd_frame.sv */
// packet framing state machine with header and crc checks
module ymd_frame (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic              action,
  input  logic [7:0]        rx_byte,
  output logic              res_valid,
  output ymd_pkg::res_t     res
);

  typedef enum logic [2:0] {
    PH_MARKER    = 3'd0,
    PH_BLOCK     = 3'd1,
    PH_BLOCK_INV = 3'd2,
    PH_DATA      = 3'd3,
    PH_CRC_HI    = 3'd4,
    PH_CRC_LO    = 3'd5,
    PH_SKIP      = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic        long_packet, long_packet_next;
  logic [10:0] byte_count, byte_count_next;
  logic [7:0]  seq_number, seq_number_next;
  logic [7:0]  seq_complement, seq_complement_next;
  logic [15:0] crc_register, crc_register_next;
  logic [7:0]  crc_high_byte, crc_high_byte_next;

  logic [10:0] len;
  logic [10:0] count_inc;
  logic [7:0]  seq_sum;

  assign len       = long_packet ? ymd_pkg::LONG_LEN : ymd_pkg::SHORT_LEN;
  assign count_inc = byte_count + 11'd1;
  assign seq_sum   = seq_number + rx_byte;

  always_comb begin
    phase_next          = phase;
    long_packet_next    = long_packet;
    byte_count_next     = byte_count;
    seq_number_next     = seq_number;
    seq_complement_next = seq_complement;
    crc_register_next   = crc_register;
    crc_high_byte_next  = crc_high_byte;
    res_valid           = 1'b0;
    res                 = '0;
    res.kind            = ymd_pkg::KIND_STATUS;
    if (accept) begin
      if (action) begin
        res_valid  = 1'b1;
        res.status = ymd_pkg::ST_TIMEOUT;
        phase_next = PH_MARKER;
      end else begin
        unique case (phase)
          PH_BLOCK: begin
            seq_number_next = rx_byte;
            phase_next      = PH_BLOCK_INV;
          end
          PH_BLOCK_INV: begin
            seq_complement_next = rx_byte;
            byte_count_next     = '0;
            if (seq_sum != ymd_pkg::SEQ_SUM) begin
              phase_next = PH_SKIP;
            end else begin
              crc_register_next = '0;
              phase_next        = PH_DATA;
            end
          end
          PH_SKIP: begin
            byte_count_next = count_inc;
            if (count_inc >= len + 11'd2) begin
              res_valid  = 1'b1;
              res.status = ymd_pkg::ST_BAD_HEADER;
              phase_next = PH_MARKER;
            end
          end
          PH_DATA: begin
            res_valid         = 1'b1;
            res.kind          = ymd_pkg::KIND_DATA;
            res.data_byte     = rx_byte;
            res.byte_index    = byte_count[9:0];
            crc_register_next = ymd_pkg::crc_step(crc_register, rx_byte);
            byte_count_next   = count_inc;
            if (count_inc >= len) begin
              phase_next = PH_CRC_HI;
            end
          end
          PH_CRC_HI: begin
            crc_high_byte_next = rx_byte;
            phase_next         = PH_CRC_LO;
          end
          PH_CRC_LO: begin
            res_valid  = 1'b1;
            phase_next = PH_MARKER;
            if ({crc_high_byte, rx_byte} != crc_register) begin
              res.status = ymd_pkg::ST_BAD_CRC;
            end else begin
              res.status        = ymd_pkg::ST_OK;
              res.block_number  = seq_number;
              res.packet_length = len;
            end
          end
          default: begin
            phase_next = PH_MARKER;
            case (rx_byte)
              ymd_pkg::MK_EOT: begin
                res_valid  = 1'b1;
                res.status = ymd_pkg::ST_EOT;
              end
              ymd_pkg::MK_CAN: begin
                res_valid  = 1'b1;
                res.status = ymd_pkg::ST_CAN;
              end
              ymd_pkg::MK_SOH, ymd_pkg::MK_STX: begin
                long_packet_next = (rx_byte == ymd_pkg::MK_STX);
                byte_count_next  = '0;
                phase_next       = PH_BLOCK;
              end
              default: begin
                res_valid  = 1'b1;
                res.status = ymd_pkg::ST_BAD_MARKER;
              end
            endcase
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_MARKER;
      long_packet    <= 1'b0;
      byte_count     <= '0;
      seq_number     <= '0;
      seq_complement <= '0;
      crc_register   <= '0;
      crc_high_byte  <= '0;
    end else begin
      phase          <= phase_next;
      long_packet    <= long_packet_next;
      byte_count     <= byte_count_next;
      seq_number     <= seq_number_next;
      seq_complement <= seq_complement_next;
      crc_register   <= crc_register_next;
      crc_high_byte  <= crc_high_byte_next;
    end
  end

endmodule

/* rtl/ymd_skid.sv */
// result register with skid stage
module ymd_skid (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  ymd_pkg::res_t push_data,
  output logic          ready,
  output logic          out_valid,
  input  logic          out_ready,
  output ymd_pkg::res_t out_data
);

  logic          skid_valid;
  ymd_pkg::res_t skid_data;

  assign ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || out_ready) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= push;
      end
    end else if (push) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || out_ready) begin
      out_data <= skid_valid ? skid_data : push_data;
    end else if (push) begin
      skid_data <= push_data;
    end
  end

endmodule

/* rtl/ymodem_packet_deframer_crc16.sv */
// top level of the ymodem packet deframer with crc-16 check
// din carries one event per transfer: action 0 with a received byte in
// rx_byte, or action 1 for a receive timeout. dout carries at most one
// result per input transfer: a payload byte with its index (kind 0) or a
// packet status (kind 1) with block number and length on a good packet.
// each event is handled in the cycle it is taken; its result is registered
// in the result register, or in the skid entry while dout stalls, before
// it appears on dout. the block takes one transfer every cycle while din
// ready is high. the rate is set by the byte-wide crc update in the framing
// stage, which sits between the input handshake and the result register.
// a result register plus one skid entry sit on the output side, so din
// keeps taking transfers while a result waits; when both are full, din
// ready drops until dout drains.
// synchronous reset returns the framer to waiting for a marker byte with
// crc and counters cleared, and empties the output stages.
module ymodem_packet_deframer_crc16 (
  input logic      clk,
  input logic      rst,
  ymd_in_if.sink   din,
  ymd_out_if.source dout
);

  logic          accept;
  logic          res_valid;
  logic          skid_ready;
  ymd_pkg::res_t res;
  ymd_pkg::res_t out_data;

  assign din.ready = skid_ready;
  assign accept    = din.valid && skid_ready;

  ymd_frame u_frame (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .action    (din.action),
    .rx_byte   (din.rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  ymd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .ready     (skid_ready),
    .out_valid (dout.valid),
    .out_ready (dout.ready),
    .out_data  (out_data)
  );

  assign dout.kind          = out_data.kind;
  assign dout.data_byte     = out_data.data_byte;
  assign dout.byte_index    = out_data.byte_index;
  assign dout.status        = out_data.status;
  assign dout.block_number  = out_data.block_number;
  assign dout.packet_length = out_data.packet_length;

endmodule
